>>> hw/rtl/wqlu_pkg.sv
package wqlu_pkg;

    localparam int STATE_COUNT = 5;

    localparam int Q_W        = 40;
    localparam int LS_W       = 3;
    localparam int ACT_W      = 3;
    localparam int ALPHA_W    = 17;
    localparam int SCALE_W    = 32;
    localparam int WLEN_W     = 7;
    localparam int ACNT_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA = 3'd0,
        CFG_GAMMA = 3'd1,
        CFG_SCALE = 3'd2,
        CFG_WLEN  = 3'd3,
        CFG_ACNT  = 3'd4
    } cfg_idx_t;

    localparam logic [ALPHA_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd6554;
    localparam logic [ALPHA_W-1:0] GAMMA_RST = 17'd58982;
    localparam logic [SCALE_W-1:0] SCALE_RST = 32'd65536;
    localparam logic [WLEN_W-1:0]  WLEN_RST  = 7'd16;
    localparam logic [ACNT_W-1:0]  ACNT_RST  = 4'd3;

    localparam logic [LS_W-1:0] LS_STRONG_GAIN = 3'd0;
    localparam logic [LS_W-1:0] LS_GAIN        = 3'd1;
    localparam logic [LS_W-1:0] LS_FLAT        = 3'd2;
    localparam logic [LS_W-1:0] LS_LOSS        = 3'd3;
    localparam logic [LS_W-1:0] LS_STRONG_LOSS = 3'd4;

    // x / 10 == (x * RECIP10) >> 35 for every 32-bit x
    localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
    localparam int          QUOT_LSB  = 35;
    localparam int          QUOT_W    = 29;

    localparam int WIDE_W      = 64;
    localparam int CHUNK_W     = 16;
    localparam int CHUNKS      = WIDE_W / CHUNK_W;
    localparam int CHUNK_IDX_W = 2;
    localparam int ACC_W       = 81;
    localparam int FRAC_W      = 16;
    localparam int SCAN_IDX_W  = 4;

    localparam logic [CHUNK_IDX_W-1:0] CHUNK_TOP = CHUNK_IDX_W'(CHUNKS - 1);

    localparam logic signed [WIDE_W-1:0] Q_HI = 64'sd549755813887;
    localparam logic signed [WIDE_W-1:0] Q_LO = -64'sd549755813888;

    // (r * 2^16 + 5) / 10 rounded down, fractional part for remainder r
    function automatic logic [FRAC_W-1:0] tenth_frac(input logic [3:0] r);
        logic [FRAC_W-1:0] v;
        case (r)
            4'd1:    v = 16'd6554;
            4'd2:    v = 16'd13107;
            4'd3:    v = 16'd19661;
            4'd4:    v = 16'd26214;
            4'd5:    v = 16'd32768;
            4'd6:    v = 16'd39322;
            4'd7:    v = 16'd45875;
            4'd8:    v = 16'd52429;
            4'd9:    v = 16'd58982;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic                   load;
        logic                   ring_start;
        logic                   ring_finish;
        logic                   class_mul;
        logic                   class_cmp;
        logic                   scan_rd;
        logic [SCAN_IDX_W-1:0]  scan_idx;
        logic                   mul_step;
        logic                   mul_first;
        logic                   mul_alpha;
        logic [CHUNK_IDX_W-1:0] chunk;
        logic                   target;
        logic                   commit;
    } wqlu_cmd_t;

    typedef struct packed {
        logic ring_full;
        logic scan_last;
        logic out_free;
    } wqlu_sts_t;

endpackage

>>> hw/rtl/wqlu_if.sv
interface wqlu_item_if #(parameter int DELTA_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   action;
    logic signed [DELTA_BITS-1:0] delta;
    logic                         accepted;

    modport source (output valid, output action, output delta, output accepted, input ready);
    modport sink (input valid, input action, input delta, input accepted, output ready);
endinterface

interface wqlu_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         new_learning_state;
    logic signed [39:0] updated_q;
    logic [2:0]         greedy_action;
    logic               saturated;

    modport source (output valid, output new_learning_state, output updated_q,
                    output greedy_action, output saturated, input ready);
    modport sink (input valid, input new_learning_state, input updated_q,
                  input greedy_action, input saturated, output ready);
endinterface

interface wqlu_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/wqlu_ram.sv
module wqlu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/wqlu_ctrl.sv
module wqlu_ctrl
    import wqlu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  wqlu_sts_t sts,
    output wqlu_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RING,
        ST_RING_UPD,
        ST_CLASS_MUL,
        ST_CLASS_CMP,
        ST_SCAN,
        ST_SCAN_END,
        ST_MUL_G,
        ST_TARGET,
        ST_MUL_A,
        ST_FIN
    } state_t;

    state_t                 state_reg, state_next;
    logic [SCAN_IDX_W-1:0]  k_reg, k_next;
    logic [CHUNK_IDX_W-1:0] c_reg, c_next;

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        c_next       = c_reg;
        cmd          = '0;
        cmd.scan_idx = k_reg;
        cmd.chunk    = c_reg;
        item_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                cmd.ring_start = 1'b1;
                state_next     = sts.ring_full ? ST_RING_UPD : ST_CLASS_MUL;
            end
            ST_RING_UPD:
            begin
                cmd.ring_finish = 1'b1;
                state_next      = ST_CLASS_MUL;
            end
            ST_CLASS_MUL:
            begin
                cmd.class_mul = 1'b1;
                state_next    = ST_CLASS_CMP;
            end
            ST_CLASS_CMP:
            begin
                cmd.class_cmp = 1'b1;
                k_next        = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_SCAN_END:
            begin
                c_next     = CHUNK_TOP;
                state_next = ST_MUL_G;
            end
            ST_MUL_G:
            begin
                cmd.mul_step  = 1'b1;
                cmd.mul_first = (c_reg == CHUNK_TOP);
                c_next        = c_reg - 1'b1;
                if (c_reg == '0)
                begin
                    state_next = ST_TARGET;
                end
            end
            ST_TARGET:
            begin
                cmd.target = 1'b1;
                c_next     = CHUNK_TOP;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.mul_step  = 1'b1;
                cmd.mul_alpha = 1'b1;
                cmd.mul_first = (c_reg == CHUNK_TOP);
                c_next        = c_reg - 1'b1;
                if (c_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.commit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
        end
    end

endmodule

>>> hw/rtl/wqlu_dp.sv
module wqlu_dp
    import wqlu_pkg::*;
#(
    parameter int MAX_ACTIONS  = 8,
    parameter int WINDOW_DEPTH = 64,
    parameter int DELTA_BITS   = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic [ACT_W-1:0]             item_action,
    input  logic signed [DELTA_BITS-1:0] item_delta,
    input  logic                         item_accepted,
    input  wqlu_cmd_t                    cmd,
    output wqlu_sts_t                    sts,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [LS_W-1:0]              res_state,
    output logic signed [Q_W-1:0]        res_q,
    output logic [ACT_W-1:0]             res_greedy,
    output logic                         res_sat
);

    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int HEAD_W  = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W   = DELTA_BITS + $clog2(WINDOW_DEPTH);
    localparam int WW      = FILL_W > WLEN_W ? FILL_W : WLEN_W;
    localparam int ACE_W   = $clog2(MAX_ACTIONS + 1);
    localparam int AW      = ACE_W > ACNT_W ? ACE_W : ACNT_W;
    localparam int AIDX_W  = MAX_ACTIONS > 1 ? $clog2(MAX_ACTIONS) : 1;
    localparam int ACMP_W  = ACE_W + ACT_W;
    localparam int SLW     = ACE_W + SCAN_IDX_W;
    localparam int QD      = STATE_COUNT * MAX_ACTIONS;
    localparam int QA_W    = $clog2(QD);
    localparam int LHS_W   = SUM_W + FRAC_W;
    localparam int BND_W   = SCALE_W + FILL_W;
    localparam int CMP_W   = (LHS_W > BND_W ? LHS_W : BND_W) + 2;

    // configuration
    logic [ALPHA_W-1:0] alpha_reg, gamma_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [WLEN_W-1:0]  wlen_reg;
    logic [ACNT_W-1:0]  acnt_reg;
    logic               wlen_wr;

    assign wlen_wr = cfg_we && (cfg_index == CFG_WLEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RST;
            gamma_reg <= GAMMA_RST;
            scale_reg <= SCALE_RST;
            wlen_reg  <= WLEN_RST;
            acnt_reg  <= ACNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA: alpha_reg <= cfg_data[ALPHA_W-1:0];
                CFG_GAMMA: gamma_reg <= cfg_data[ALPHA_W-1:0];
                CFG_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_WLEN:  wlen_reg  <= cfg_data[WLEN_W-1:0];
                CFG_ACNT:  acnt_reg  <= cfg_data[ACNT_W-1:0];
                default:   ;
            endcase
        end
    end

    logic [WW-1:0]      wlen_x;
    logic [FILL_W-1:0]  win_eff;
    logic [AW-1:0]      acnt_x;
    logic [ACE_W-1:0]   ac_eff;
    logic [ALPHA_W-1:0] a_eff, g_eff;

    assign wlen_x  = WW'(wlen_reg);
    assign win_eff = (wlen_x == '0) ? FILL_W'(1) :
                     (wlen_x > WW'(WINDOW_DEPTH)) ? FILL_W'(WINDOW_DEPTH) : FILL_W'(wlen_x);
    assign acnt_x  = AW'(acnt_reg);
    assign ac_eff  = (acnt_x == '0) ? ACE_W'(1) :
                     (acnt_x > AW'(MAX_ACTIONS)) ? ACE_W'(MAX_ACTIONS) : ACE_W'(acnt_x);
    assign a_eff   = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
    assign g_eff   = (gamma_reg > ONE_Q16) ? ONE_Q16 : gamma_reg;

    // request fields
    logic [AIDX_W-1:0]           act_reg;
    logic signed [DELTA_BITS-1:0] delta_reg;
    logic                        accf_reg;
    logic [LS_W-1:0]             s_reg, ls_reg, next_reg;
    logic [ACMP_W-1:0]           act_cmp, ac_cmp, act_cl;

    assign act_cmp = ACMP_W'(item_action);
    assign ac_cmp  = ACMP_W'(ac_eff);
    assign act_cl  = (act_cmp >= ac_cmp) ? ac_cmp - 1'b1 : act_cmp;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= act_cl[AIDX_W-1:0];
            delta_reg <= item_delta;
            accf_reg  <= item_accepted;
            s_reg     <= (ls_reg < LS_W'(STATE_COUNT)) ? ls_reg : LS_FLAT;
        end
    end

    // change ring
    logic [FILL_W-1:0]            fill_reg;
    logic [HEAD_W-1:0]            head_reg, head_eff;
    logic signed [SUM_W-1:0]      sum_reg;
    logic                         ring_we, ring_re;
    logic [HEAD_W-1:0]            ring_waddr;
    logic [DELTA_BITS-1:0]        ring_rdata;

    assign sts.ring_full = (fill_reg >= win_eff);
    assign head_eff      = (FILL_W'(head_reg) >= win_eff) ? '0 : head_reg;
    assign ring_we       = (cmd.ring_start && !sts.ring_full) || cmd.ring_finish;
    assign ring_re       = cmd.ring_start && sts.ring_full;
    assign ring_waddr    = cmd.ring_finish ? head_reg : fill_reg[HEAD_W-1:0];

    wqlu_ram #(
        .WIDTH (DELTA_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (delta_reg),
        .re    (ring_re),
        .raddr (head_eff),
        .rdata (ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            head_reg <= '0;
            sum_reg  <= '0;
        end
        else if (wlen_wr)
        begin
            fill_reg <= '0;
            head_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.ring_start)
        begin
            if (!sts.ring_full)
            begin
                sum_reg  <= sum_reg + SUM_W'(delta_reg);
                fill_reg <= fill_reg + 1'b1;
                head_reg <= '0;
            end
            else
            begin
                head_reg <= head_eff;
            end
        end
        else if (cmd.ring_finish)
        begin
            sum_reg  <= sum_reg - SUM_W'($signed(ring_rdata)) + SUM_W'(delta_reg);
            head_reg <= (FILL_W'(head_reg) + 1'b1 == win_eff) ? '0 : head_reg + 1'b1;
        end
    end

    // reward divide by ten, classification
    logic [31:0]              udelta;
    logic [63:0]              prod10;
    logic [QUOT_W-1:0]        q10_reg;
    logic [3:0]               rem_reg;
    logic [31:0]              rem_full;
    logic [BND_W-1:0]         bound_reg;
    logic signed [LHS_W-1:0]  lhs_n;
    logic signed [CMP_W-1:0]  lhs_c, bnd_c;
    logic [LS_W-1:0]          cls;
    logic signed [WIDE_W-1:0] d64, reward_n, reward_reg;

    assign udelta   = 32'($unsigned(delta_reg));
    assign prod10   = {32'h0, udelta} * {32'h0, RECIP10};
    assign rem_full = udelta - (32'(q10_reg) << 3) - (32'(q10_reg) << 1);
    assign lhs_n    = {sum_reg, 16'h0000};
    assign lhs_c    = CMP_W'(lhs_n);
    assign bnd_c    = $signed(CMP_W'(bound_reg));
    assign d64      = WIDE_W'(delta_reg);

    always_comb
    begin
        if (lhs_c <= -bnd_c)
        begin
            cls = LS_STRONG_GAIN;
        end
        else if (sum_reg < 0)
        begin
            cls = LS_GAIN;
        end
        else if (sum_reg == 0)
        begin
            cls = LS_FLAT;
        end
        else if (lhs_c < bnd_c)
        begin
            cls = LS_LOSS;
        end
        else
        begin
            cls = LS_STRONG_LOSS;
        end

        if (accf_reg)
        begin
            reward_n = -(d64 <<< FRAC_W);
        end
        else if (delta_reg > 0)
        begin
            reward_n = -((WIDE_W'(q10_reg) << FRAC_W) + WIDE_W'(tenth_frac(rem_reg)));
        end
        else
        begin
            reward_n = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ring_start)
        begin
            q10_reg <= prod10[QUOT_LSB +: QUOT_W];
        end
        if (cmd.class_mul)
        begin
            rem_reg   <= rem_full[3:0];
            bound_reg <= BND_W'(scale_reg) * BND_W'(fill_reg);
        end
        if (cmd.class_cmp)
        begin
            next_reg   <= cls;
            reward_reg <= reward_n;
        end
    end

    // Q store with per-entry valid bits
    logic [QD-1:0]           qvalid_reg;
    logic                    qv_rd_reg;
    logic                    q_re;
    logic [QA_W-1:0]         old_addr, scan_addr, q_raddr;
    logic [Q_W-1:0]          q_rdata;
    logic signed [Q_W-1:0]   q_val, nv_q;
    logic [AIDX_W-1:0]       scan_aidx;

    assign scan_aidx = cmd.scan_idx[AIDX_W-1:0];
    assign old_addr  = QA_W'(s_reg) * QA_W'(MAX_ACTIONS) + QA_W'(act_reg);
    assign scan_addr = QA_W'(next_reg) * QA_W'(MAX_ACTIONS) + QA_W'(scan_aidx);
    assign q_re      = cmd.class_mul || cmd.scan_rd;
    assign q_raddr   = cmd.class_mul ? old_addr : scan_addr;
    assign q_val     = qv_rd_reg ? $signed(q_rdata) : '0;

    wqlu_ram #(
        .WIDTH (Q_W),
        .DEPTH (QD)
    ) u_qstore (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (old_addr),
        .wdata (nv_q),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign sts.scan_last = (SLW'(cmd.scan_idx) + 1'b1 == SLW'(ac_eff));

    // row scan: maximum, and first best with the written entry set aside
    logic                  pend_reg;
    logic [AIDX_W-1:0]     pidx_reg;
    logic signed [Q_W-1:0] old_reg, max_reg, bval_reg;
    logic [AIDX_W-1:0]     bidx_reg;
    logic                  bvld_reg;
    logic                  same_row, excluded;

    assign same_row = (s_reg == next_reg);
    assign excluded = same_row && (pidx_reg == act_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qvalid_reg <= '0;
            qv_rd_reg  <= 1'b0;
            pend_reg   <= 1'b0;
            bvld_reg   <= 1'b0;
            ls_reg     <= LS_FLAT;
        end
        else
        begin
            if (q_re)
            begin
                qv_rd_reg <= qvalid_reg[q_raddr];
            end
            pend_reg <= cmd.scan_rd;
            if (cmd.class_cmp)
            begin
                bvld_reg <= 1'b0;
            end
            else if (pend_reg && !excluded && (!bvld_reg || q_val > bval_reg))
            begin
                bvld_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                qvalid_reg[old_addr] <= 1'b1;
                ls_reg               <= next_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            pidx_reg <= scan_aidx;
        end
        if (cmd.class_cmp)
        begin
            old_reg <= q_val;
        end
        if (pend_reg)
        begin
            if (pidx_reg == '0 || q_val > max_reg)
            begin
                max_reg <= q_val;
            end
            if (!excluded && (!bvld_reg || q_val > bval_reg))
            begin
                bval_reg <= q_val;
                bidx_reg <= pidx_reg;
            end
        end
    end

    // shared multiplier: 17-bit fraction times 64-bit operand, 16 bits a cycle
    logic [ALPHA_W-1:0]         a_op;
    logic signed [WIDE_W-1:0]   b_op, diff_reg, rnd64, nv_full;
    logic [CHUNK_W-1:0]         chunk;
    logic signed [CHUNK_W:0]    chunk_x;
    logic signed [ALPHA_W+CHUNK_W+1:0] pp;
    logic signed [ACC_W-1:0]    acc_reg, racc;

    assign a_op    = cmd.mul_alpha ? a_eff : g_eff;
    assign b_op    = cmd.mul_alpha ? diff_reg : WIDE_W'(max_reg);
    assign chunk   = b_op[cmd.chunk*CHUNK_W +: CHUNK_W];
    assign chunk_x = (cmd.chunk == CHUNK_TOP) ? $signed({chunk[CHUNK_W-1], chunk})
                                              : $signed({1'b0, chunk});
    assign pp      = $signed({1'b0, a_op}) * chunk_x;
    assign racc    = acc_reg + ACC_W'(32768);
    assign rnd64   = racc[FRAC_W +: WIDE_W];
    assign nv_full = WIDE_W'(old_reg) + rnd64;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step)
        begin
            acc_reg <= cmd.mul_first ? ACC_W'(pp) : (acc_reg <<< CHUNK_W) + ACC_W'(pp);
        end
        if (cmd.target)
        begin
            diff_reg <= reward_reg + rnd64 - WIDE_W'(old_reg);
        end
    end

    // final value, saturation, greedy choice
    logic              sat_n;
    logic [AIDX_W-1:0] greedy;
    logic              out_vld_reg;

    always_comb
    begin
        sat_n = 1'b0;
        nv_q  = nv_full[Q_W-1:0];
        if (nv_full > Q_HI)
        begin
            nv_q  = Q_HI[Q_W-1:0];
            sat_n = 1'b1;
        end
        else if (nv_full < Q_LO)
        begin
            nv_q  = Q_LO[Q_W-1:0];
            sat_n = 1'b1;
        end

        if (!same_row)
        begin
            greedy = bidx_reg;
        end
        else if (!bvld_reg || nv_q > bval_reg)
        begin
            greedy = act_reg;
        end
        else if (nv_q == bval_reg && act_reg < bidx_reg)
        begin
            greedy = act_reg;
        end
        else
        begin
            greedy = bidx_reg;
        end
    end

    assign sts.out_free = !out_vld_reg || res_ready;
    assign res_valid    = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_state  <= next_reg;
            res_q      <= nv_q;
            res_greedy <= ACT_W'(greedy);
            res_sat    <= sat_n;
        end
    end

endmodule

>>> hw/rtl/windowed_q_learning_update.sv
// Channel   Dir  Handshake          Request fields
// item      in   valid/ready        action[2:0], delta[DELTA_BITS-1:0] signed, accepted
// result    out  valid/ready        new_learning_state[2:0], updated_q[39:0] signed,
//                                   greedy_action[2:0], saturated
// cfg       in   valid/ready (=1)   index[2:0], data[31:0]
//
// One request at a time. The row scan reads the n Q entries in use, n the action count,
// through the one read port of the Q memory; when the ring is full, the oldest change is
// read back first. Two 17 x 64 products are formed 16 bits a cycle in one multiplier.
// Reset: config to defaults, ring empty, learning state 2, all Q valid bits clear.
// A stalled result holds the block in its last step; the next request waits for it.
module windowed_q_learning_update
    import wqlu_pkg::*;
#(
    parameter int MAX_ACTIONS  = 8,
    parameter int WINDOW_DEPTH = 64,
    parameter int DELTA_BITS   = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    wqlu_item_if.sink     item,
    wqlu_cfg_if.sink      cfg,
    wqlu_result_if.source result
);

    wqlu_cmd_t cmd;
    wqlu_sts_t sts;

    assign cfg.ready = 1'b1;

    wqlu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    wqlu_dp #(
        .MAX_ACTIONS  (MAX_ACTIONS),
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .DELTA_BITS   (DELTA_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .item_action   (item.action),
        .item_delta    (item.delta),
        .item_accepted (item.accepted),
        .cmd           (cmd),
        .sts           (sts),
        .res_valid     (result.valid),
        .res_ready     (result.ready),
        .res_state     (result.new_learning_state),
        .res_q         (result.updated_q),
        .res_greedy    (result.greedy_action),
        .res_sat       (result.saturated)
    );

endmodule

>>> tb/windowed_q_learning_update_tb.sv
`timescale 1ns / 100ps

module windowed_q_learning_update_tb;
    import wqlu_pkg::*;

    localparam int     MAX_ACT     = 8;
    localparam int     WIN_DEPTH   = 64;
    localparam int     DBITS       = 24;
    localparam longint UNITY       = 65536;
    localparam longint Q_MAX       = (longint'(1) <<< 39) - 1;
    localparam longint Q_MIN       = -Q_MAX - 1;
    localparam int     CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_FIRST = CFG_ACNT + 1;

    typedef struct {
        logic [ACT_W-1:0]       action;
        logic signed [DBITS-1:0] delta;
        logic                   accepted;
    } move_t;

    typedef struct {
        logic [LS_W-1:0]       state;
        logic signed [Q_W-1:0] q;
        logic [ACT_W-1:0]      greedy;
        logic                  sat;
    } q_update_t;

    logic clk = 1'b0;
    logic rst_n;
    logic holding;

    int send_idle_pct;
    int stall_pct;
    int mismatch_count = 0;
    int cycle_count = 0;

    move_t     pending_moves[$];
    q_update_t expected_updates[$];

    // predictor state
    int     alpha_val, gamma_val, wlen_val, acnt_val;
    longint scale_val;
    longint q_table[STATE_COUNT * MAX_ACT];
    longint change_ring[WIN_DEPTH];
    longint ring_sum;
    int     ring_fill, ring_head, learn_state;

    wqlu_item_if #(.DELTA_BITS(DBITS)) item_ch();
    wqlu_result_if                     result_ch();
    wqlu_cfg_if                        cfg_ch();

    windowed_q_learning_update #(
        .MAX_ACTIONS (MAX_ACT),
        .WINDOW_DEPTH(WIN_DEPTH),
        .DELTA_BITS  (DBITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .cfg   (cfg_ch),
        .result(result_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void empty_ring();
        foreach (change_ring[i])
            change_ring[i] = 0;
        ring_sum  = 0;
        ring_fill = 0;
        ring_head = 0;
    endfunction

    function automatic void reset_prediction();
        alpha_val = int'(ALPHA_RST);
        gamma_val = int'(GAMMA_RST);
        scale_val = longint'({32'b0, SCALE_RST});
        wlen_val  = int'(WLEN_RST);
        acnt_val  = int'(ACNT_RST);
        foreach (q_table[i])
            q_table[i] = 0;
        empty_ring();
        learn_state = int'(LS_FLAT);
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_ALPHA: alpha_val = int'(value[16:0]);
            CFG_GAMMA: gamma_val = int'(value[16:0]);
            CFG_SCALE: scale_val = longint'({32'b0, value});
            CFG_WLEN:
            begin
                wlen_val = int'(value[6:0]);
                empty_ring();
            end
            CFG_ACNT:  acnt_val = int'(value[3:0]);
            default:   ;
        endcase
    endfunction

    function automatic q_update_t predict_q_update(logic [ACT_W-1:0] act_in,
                                                   logic signed [DBITS-1:0] d_in,
                                                   logic acc);
        int        acts, win, act, nxt, cur, best;
        longint    a_eff, g_eff, dl, reward, old_q, row_max, target, nv, lhs, bound;
        q_update_t r;
        acts  = (acnt_val == 0) ? 1 : ((acnt_val > MAX_ACT) ? MAX_ACT : acnt_val);
        win   = (wlen_val == 0) ? 1 : ((wlen_val > WIN_DEPTH) ? WIN_DEPTH : wlen_val);
        a_eff = (alpha_val > UNITY) ? UNITY : alpha_val;
        g_eff = (gamma_val > UNITY) ? UNITY : gamma_val;
        act   = int'(act_in);
        if (act >= acts)
            act = acts - 1;
        dl = d_in;

        if (ring_fill < win)
        begin
            change_ring[ring_fill] = dl;
            ring_sum  += dl;
            ring_fill += 1;
            ring_head  = 0;
        end
        else
        begin
            if (ring_head >= win)
                ring_head = 0;
            ring_sum -= change_ring[ring_head];
            change_ring[ring_head] = dl;
            ring_sum += dl;
            ring_head = (ring_head + 1) % win;
        end

        lhs   = ring_sum * UNITY;
        bound = scale_val * ring_fill;
        if (lhs <= -bound)
            nxt = int'(LS_STRONG_GAIN);
        else if (ring_sum < 0)
            nxt = int'(LS_GAIN);
        else if (ring_sum == 0)
            nxt = int'(LS_FLAT);
        else if (lhs < bound)
            nxt = int'(LS_LOSS);
        else
            nxt = int'(LS_STRONG_LOSS);

        if (acc)
            reward = -dl * UNITY;
        else if (dl > 0)
            reward = -((dl * UNITY + 5) / 10);
        else
            reward = 0;

        cur     = (learn_state < STATE_COUNT) ? learn_state : int'(LS_FLAT);
        old_q   = q_table[cur * MAX_ACT + act];
        row_max = q_table[nxt * MAX_ACT];
        for (int k = 1; k < acts; k++)
            if (q_table[nxt * MAX_ACT + k] > row_max)
                row_max = q_table[nxt * MAX_ACT + k];

        target = reward + ((g_eff * row_max + 32768) >>> 16);
        nv     = old_q + ((a_eff * (target - old_q) + 32768) >>> 16);
        r.sat  = 1'b0;
        if (nv > Q_MAX)
        begin
            nv    = Q_MAX;
            r.sat = 1'b1;
        end
        if (nv < Q_MIN)
        begin
            nv    = Q_MIN;
            r.sat = 1'b1;
        end
        q_table[cur * MAX_ACT + act] = nv;

        best = 0;
        for (int k = 1; k < acts; k++)
            if (q_table[nxt * MAX_ACT + k] > q_table[nxt * MAX_ACT + best])
                best = k;

        learn_state = nxt;
        r.state  = nxt[LS_W-1:0];
        r.q      = nv[Q_W-1:0];
        r.greedy = best[ACT_W-1:0];
        return r;
    endfunction

    // request driver
    always @(posedge clk)
    begin : drive_moves
        move_t m;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                expected_updates.push_back(predict_q_update(item_ch.action, item_ch.delta,
                                                            item_ch.accepted));
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_moves.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    m = pending_moves.pop_front();
                    item_ch.valid    <= 1'b1;
                    item_ch.action   <= m.action;
                    item_ch.delta    <= m.delta;
                    item_ch.accepted <= m.accepted;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            result_ch.ready <= !holding && ($urandom_range(99) >= stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin : check_updates
        q_update_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_updates.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: state %0d q %0d greedy %0d sat %0b",
                             result_ch.new_learning_state, result_ch.updated_q,
                             result_ch.greedy_action, result_ch.saturated);
            end
            else
            begin
                want = expected_updates.pop_front();
                if (want.state !== result_ch.new_learning_state || want.q !== result_ch.updated_q
                    || want.greedy !== result_ch.greedy_action
                    || want.sat !== result_ch.saturated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected state %0d q %0d greedy %0d sat %0b, got %s",
                                 want.state, want.q, want.greedy, want.sat,
                                 $sformatf("state %0d q %0d greedy %0d sat %0b",
                                           result_ch.new_learning_state, result_ch.updated_q,
                                           result_ch.greedy_action, result_ch.saturated));
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic add_move(int act, int d, bit acc);
        move_t m;
        m.action   = act[ACT_W-1:0];
        m.delta    = d[DBITS-1:0];
        m.accepted = acc;
        pending_moves.push_back(m);
    endtask

    function automatic move_t random_move();
        move_t m;
        int    v;
        m.action   = ACT_W'($urandom_range(7));
        m.accepted = $urandom_range(1);
        case ($urandom_range(9))
            0, 1, 2: v = int'($urandom_range(8)) - 4;
            3:       v = 0;
            4:
            begin
                case ($urandom_range(3))
                    0:       v = -8388608;
                    1:       v = 8388607;
                    2:       v = -1;
                    default: v = 1;
                endcase
            end
            5:       v = int'($urandom_range(200000)) - 100000;
            default: v = int'($urandom);
        endcase
        m.delta = v[DBITS-1:0];
        return m;
    endfunction

    task automatic queue_random_moves(int count);
        @(negedge clk);
        repeat (count)
            pending_moves.push_back(random_move());
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_moves.size() != 0 || item_ch.valid || expected_updates.size() != 0);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_register(idx, value);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        @(negedge clk);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1:
            begin
                send_idle_pct = 85;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 85;
            end
            default:
            begin
                send_idle_pct = 25;
                stall_pct     = 25;
            end
        endcase
    endtask

    task automatic hold_results(int cycles);
        holding <= 1'b1;
        repeat (cycles)
            @(posedge clk);
        holding <= 1'b0;
    endtask

    // set unused upper data bits at random
    function automatic logic [CFG_DATA_W-1:0] with_noise(longint v, int w);
        logic [CFG_DATA_W-1:0] d;
        d = v[CFG_DATA_W-1:0];
        if ($urandom_range(1) == 1)
            d = d | ($urandom << w);
        return d;
    endfunction

    task automatic write_random_settings();
        longint v;
        case ($urandom_range(4))
            0:       v = 0;
            1:       v = UNITY;
            2:       v = $urandom_range(131071, 65537);
            3:       v = $urandom_range(65536);
            default: v = $urandom_range(13107, 3277);
        endcase
        write_register(CFG_ALPHA, with_noise(v, ALPHA_W));
        case ($urandom_range(4))
            0:       v = 0;
            1:       v = UNITY;
            2:       v = $urandom_range(131071, 65537);
            default: v = $urandom_range(65536);
        endcase
        write_register(CFG_GAMMA, with_noise(v, ALPHA_W));
        case ($urandom_range(5))
            0:       v = 0;
            1:       v = 1;
            2:       v = 32'hFFFF_FFFF;
            3:       v = UNITY * $urandom_range(4, 1);
            4:       v = $urandom;
            default: v = $urandom_range(524288, 1);
        endcase
        write_register(CFG_SCALE, v[CFG_DATA_W-1:0]);
        if ($urandom_range(1) == 1)
        begin
            case ($urandom_range(6))
                0:       v = 0;
                1:       v = 1;
                2:       v = 2;
                3:       v = 64;
                4:       v = $urandom_range(127, 65);
                5:       v = $urandom_range(8, 1);
                default: v = $urandom_range(64, 1);
            endcase
            write_register(CFG_WLEN, with_noise(v, WLEN_W));
        end
        case ($urandom_range(4))
            0:       v = 0;
            1:       v = 1;
            2:       v = 8;
            3:       v = $urandom_range(15, 9);
            default: v = $urandom_range(8, 1);
        endcase
        write_register(CFG_ACNT, with_noise(v, ACNT_W));
        if ($urandom_range(3) == 0)
            write_register(SPARE_IDX_FIRST + CFG_IDX_W'($urandom_range(2)), $urandom);
    endtask

    initial
    begin : run
        rst_n            = 1'b0;
        holding          = 1'b0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        item_ch.valid    = 1'b0;
        item_ch.action   = '0;
        item_ch.delta    = '0;
        item_ch.accepted = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_ALPHA;
        cfg_ch.data      = '0;
        result_ch.ready  = 1'b0;
        reset_prediction();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // defaults: field extremes, rejected worsening moves, actions past the count
        @(negedge clk);
        add_move(0, 0, 1);
        add_move(1, 8388607, 1);
        add_move(2, -8388608, 1);
        add_move(7, 5, 0);
        add_move(3, -7, 0);
        add_move(4, 1, 0);
        add_move(5, -1, 1);
        add_move(6, 0, 0);
        add_move(0, 8388607, 0);
        add_move(1, 3, 1);
        wait_drained();

        // unity rates, zero scale, zero window and action count, spare indexes
        write_register(CFG_ALPHA, 32'd65536);
        write_register(CFG_GAMMA, 32'd65536);
        write_register(CFG_SCALE, 32'd0);
        write_register(CFG_WLEN, 32'd0);
        write_register(CFG_ACNT, 32'd0);
        for (int i = 0; i < 3; i++)
            write_register(SPARE_IDX_FIRST + CFG_IDX_W'(i), 32'h0000_0001);
        @(negedge clk);
        add_move(2, -8388608, 1);
        add_move(2, -8388608, 1);
        add_move(2, -8388608, 1);
        add_move(0, 8388607, 1);
        add_move(0, 0, 0);
        add_move(5, -3, 0);
        wait_drained();

        // rates above one, largest scale, oversized window and action count
        write_register(CFG_ALPHA, 32'h0001_FFFF);
        write_register(CFG_GAMMA, 32'h0001_FFFF);
        write_register(CFG_SCALE, 32'hFFFF_FFFF);
        write_register(CFG_WLEN, 32'd127);
        write_register(CFG_ACNT, 32'd15);
        @(negedge clk);
        for (int i = 0; i < 8; i++)
        begin
            if (i % 2 == 0)
                add_move(i, 8388607, 1);
            else
                add_move(i, -8388608, i % 4 == 1);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_random_settings();
            set_idling(ph % 4);
            queue_random_moves(60);
        end

        // long result hold-off with the sender at full rate
        wait_drained();
        write_random_settings();
        set_idling(0);
        fork
            hold_results(400);
        join_none
        queue_random_moves(25);

        // short bursts, each drained before the next
        wait_drained();
        set_idling(3);
        repeat (5)
        begin
            wait_drained();
            queue_random_moves(4);
        end

        wait_drained();
        repeat (40)
            @(posedge clk);
        if (mismatch_count == 0 && expected_updates.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
